// ----- rtl/core/power_detector_bias_loop_macros.svh -----
// Assertion macros for the power detector bias loop.
// Both macros clock on aclk and are disabled while aresetn is low.
`ifndef POWER_DETECTOR_BIAS_LOOP_MACROS_SVH
`define POWER_DETECTOR_BIAS_LOOP_MACROS_SVH

// Condition that must hold at every clock edge.
`define PDBL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define PDBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/pdbl_pkg.sv -----
// Shared types and constants for the power detector bias loop.
// Used by pdbl_div and power_detector_bias_loop; depends on nothing.
`default_nettype none

package pdbl_pkg;

    localparam int MV_W     = 12;
    localparam int TEMP_W   = 8;
    localparam int ADC_W    = 16;
    localparam int CD_W     = 7;
    localparam int CFG_A_W  = 3;
    localparam int ERR_W    = 13;
    localparam int BIAS_S_W = 14;

    // derating divider: limit difference times temperature offset over the span
    localparam int DIV_NUM_W = 20;
    localparam int DIV_DEN_W = 8;
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

    // shared multiplier
    localparam int MUL_A_W = 16;
    localparam int MUL_B_W = 21;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // 4095/3300 reduces to 273/220; ceil(2^20 * 273/220) is exact for any 12-bit bias
    localparam int                 DAC_SHIFT = 20;
    localparam logic [MUL_B_W-1:0] DAC_RECIP = 21'd1301188;

    localparam logic [MV_W-1:0]      MV_FULL     = 12'd3300;
    localparam logic [ADC_W-1:0]     ADC_FULL    = 16'd65535;
    localparam logic [MV_W-1:0]      DAC_MAX     = 12'd4095;
    localparam logic [CD_W-1:0]      SAVE_HOLD   = 7'd100;
    localparam logic signed [ERR_W-1:0]    ERR_BAND    = 13'sd100;
    localparam logic signed [BIAS_S_W-1:0] STEP_FINE   = 14'sd1;
    localparam logic signed [BIAS_S_W-1:0] STEP_COARSE = 14'sd10;

    // configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_TARGET_NORMAL = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_LIMIT_WARNING = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_LIMIT_DANGER  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_TEMP_WARNING  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_TEMP_DANGER   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_VREF_MAX      = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_VREF_INIT     = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MEAS,
        ST_MEAS_FIX,
        ST_DER,
        ST_DER_WAIT,
        ST_STEP,
        ST_DAC,
        ST_DAC_FIX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/pdbl_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on pdbl_pkg for widths and the request/response structs.
`default_nettype none

module pdbl_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pdbl_pkg::div_req_t req,
    output pdbl_pkg::div_rsp_t      rsp
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [pdbl_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [pdbl_pkg::DIV_DEN_W-1:0]    rem_reg, rem_next;
    logic [pdbl_pkg::DIV_NUM_W-1:0]    quo_reg, quo_next;
    logic [pdbl_pkg::DIV_DEN_W-1:0]    den_reg, den_next;
    logic [pdbl_pkg::DIV_DEN_W:0]      shifted;
    logic [pdbl_pkg::DIV_DEN_W:0]      trial;
    logic                              fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[pdbl_pkg::DIV_NUM_W-1]};
        trial   = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;

        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the low bits hold it
            rem_next = fits ? trial[pdbl_pkg::DIV_DEN_W-1:0]
                            : shifted[pdbl_pkg::DIV_DEN_W-1:0];
            quo_next = {quo_reg[pdbl_pkg::DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pdbl_pkg::DIV_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/core/power_detector_bias_loop.sv -----
// Power detector bias loop. A control word (tuser 0) turns the detector sample into
// millivolts, derates the target between the warning and danger temperatures, steps
// the bias by 1 or 10 mV toward the target unless the error is zero, clamps it and
// returns the DAC code plus a save request when the hold countdown expires below the
// warning temperature. A reload word (tuser 1) loads the bias from vref_init_reg. One
// word is in flight at a time and s_tready is low while it runs. Sample, derating and
// DAC scaling share one 16x21 multiplier (the constant divisions become a carry fold
// and a reciprocal product); the derating ratio runs through a bit-serial divider.
// The next input word is taken while the previous result still waits on m_tready;
// a result still waiting holds the next one back in ST_DONE until it is taken.
// Depends on pdbl_pkg, pdbl_div and power_detector_bias_loop_macros.svh.
`default_nettype none

`include "power_detector_bias_loop_macros.svh"

module power_detector_bias_loop (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [11:0] cfg_wr_data,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // adc_sample[15:0], temperature[23:16]
    input  wire logic [0:0]  s_tuser,   // mode[0]
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // dac_code[11:0], bias_mv[23:12], measured_mv[35:24], target_mv[47:36],
    // save_valid[48], save_bias_mv[60:49], zero[63:61]
    output logic [63:0]      m_tdata
);

    // configuration registers
    logic [pdbl_pkg::MV_W-1:0]   target_normal_reg;
    logic [pdbl_pkg::MV_W-1:0]   limit_warning_reg;
    logic [pdbl_pkg::MV_W-1:0]   limit_danger_reg;
    logic [pdbl_pkg::TEMP_W-1:0] temp_warning_reg;
    logic [pdbl_pkg::TEMP_W-1:0] temp_danger_reg;
    logic [pdbl_pkg::MV_W-1:0]   vref_max_reg;
    logic [pdbl_pkg::MV_W-1:0]   vref_init_reg;

    pdbl_pkg::state_t state_reg, state_next;

    // loop state
    logic [pdbl_pkg::MV_W-1:0] bias_reg, bias_next;
    logic [pdbl_pkg::CD_W-1:0] cd_reg, cd_next;

    // working registers
    logic [pdbl_pkg::ADC_W-1:0]  sample_reg, sample_next;
    logic [pdbl_pkg::TEMP_W-1:0] temp_reg, temp_next;
    logic [pdbl_pkg::MV_W-1:0]   meas_reg, meas_next;
    logic [pdbl_pkg::MV_W-1:0]   target_reg, target_next;
    logic                        save_reg, save_next;
    logic [pdbl_pkg::MV_W-1:0]   save_bias_reg, save_bias_next;
    logic [pdbl_pkg::MV_W-1:0]   dac_reg, dac_next;
    logic [pdbl_pkg::PROD_W-1:0] prod_reg, prod_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg, m_data_next;

    pdbl_pkg::div_req_t div_req;
    pdbl_pkg::div_rsp_t div_rsp;

    logic [pdbl_pkg::MUL_A_W-1:0] mul_a;
    logic [pdbl_pkg::MUL_B_W-1:0] mul_b;
    logic [pdbl_pkg::PROD_W-1:0]  product;
    logic [pdbl_pkg::ADC_W:0]     meas_sum;
    logic [pdbl_pkg::MV_W-1:0]    meas_fix;
    logic [pdbl_pkg::MV_W-1:0]    lim_diff;
    logic [pdbl_pkg::TEMP_W-1:0]  temp_off;
    logic [pdbl_pkg::TEMP_W-1:0]  temp_span;
    logic [pdbl_pkg::MV_W-1:0]    der_limit;
    logic signed [pdbl_pkg::ERR_W-1:0]    err;
    logic signed [pdbl_pkg::BIAS_S_W-1:0] bias_s;
    logic                                 err_big;
    logic [pdbl_pkg::CD_W-1:0]            cd_load;
    logic                                 accept;

    pdbl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == pdbl_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign lim_diff  = (limit_warning_reg > limit_danger_reg) ?
                       (limit_warning_reg - limit_danger_reg) : '0;
    assign temp_off  = temp_reg - temp_warning_reg;
    assign temp_span = temp_danger_reg - temp_warning_reg;
    assign product   = mul_a * mul_b;

    // x/65535 = (x>>16) plus one when (x>>16) + (x & 0xffff) reaches 65535
    assign meas_sum = {5'b00000, prod_reg[pdbl_pkg::ADC_W+pdbl_pkg::MV_W-1:pdbl_pkg::ADC_W]} +
                      {1'b0, prod_reg[pdbl_pkg::ADC_W-1:0]};
    assign meas_fix = prod_reg[pdbl_pkg::ADC_W+pdbl_pkg::MV_W-1:pdbl_pkg::ADC_W] +
                      {11'h000, (meas_sum >= {1'b0, pdbl_pkg::ADC_FULL})};

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_normal_reg <= '0;
            limit_warning_reg <= pdbl_pkg::MV_FULL;
            limit_danger_reg  <= pdbl_pkg::MV_FULL;
            temp_warning_reg  <= 8'd80;
            temp_danger_reg   <= 8'd100;
            vref_max_reg      <= pdbl_pkg::MV_FULL;
            vref_init_reg     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pdbl_pkg::REG_TARGET_NORMAL: target_normal_reg <= cfg_wr_data;
                pdbl_pkg::REG_LIMIT_WARNING: limit_warning_reg <= cfg_wr_data;
                pdbl_pkg::REG_LIMIT_DANGER:  limit_danger_reg  <= cfg_wr_data;
                pdbl_pkg::REG_TEMP_WARNING:  temp_warning_reg  <= cfg_wr_data[7:0];
                pdbl_pkg::REG_TEMP_DANGER:   temp_danger_reg   <= cfg_wr_data[7:0];
                pdbl_pkg::REG_VREF_MAX:      vref_max_reg      <= cfg_wr_data;
                pdbl_pkg::REG_VREF_INIT:     vref_init_reg     <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        bias_next      = bias_reg;
        cd_next        = cd_reg;
        sample_next    = sample_reg;
        temp_next      = temp_reg;
        meas_next      = meas_reg;
        target_next    = target_reg;
        save_next      = save_reg;
        save_bias_next = save_bias_reg;
        dac_next       = dac_reg;
        prod_next      = prod_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;

        mul_a            = sample_reg;
        mul_b            = {9'h000, pdbl_pkg::MV_FULL};
        div_req.start    = 1'b0;
        div_req.dividend = product[pdbl_pkg::DIV_NUM_W-1:0];
        div_req.divisor  = temp_span;

        der_limit = limit_warning_reg - div_rsp.quotient[pdbl_pkg::MV_W-1:0];
        err       = $signed({1'b0, meas_reg}) - $signed({1'b0, target_reg});
        bias_s    = $signed({2'b00, bias_reg});
        err_big   = 1'b0;
        cd_load   = cd_reg;

        case (state_reg)
            pdbl_pkg::ST_IDLE: begin
                if (accept) begin
                    sample_next = s_tdata[15:0];
                    temp_next   = s_tdata[23:16];
                    if (s_tuser[0]) begin
                        bias_next      = vref_init_reg;
                        meas_next      = '0;
                        target_next    = '0;
                        save_next      = 1'b0;
                        save_bias_next = '0;
                        state_next     = pdbl_pkg::ST_DAC;
                    end else begin
                        state_next = pdbl_pkg::ST_MEAS;
                    end
                end
            end
            pdbl_pkg::ST_MEAS: begin
                // sample * 3300
                prod_next  = product;
                state_next = pdbl_pkg::ST_MEAS_FIX;
            end
            pdbl_pkg::ST_MEAS_FIX: begin
                meas_next = meas_fix;
                if (temp_reg <= temp_warning_reg) begin
                    target_next = target_normal_reg;
                    state_next  = pdbl_pkg::ST_STEP;
                end else if (temp_reg >= temp_danger_reg) begin
                    target_next = (limit_danger_reg < target_normal_reg) ?
                                  limit_danger_reg : target_normal_reg;
                    state_next  = pdbl_pkg::ST_STEP;
                end else begin
                    state_next = pdbl_pkg::ST_DER;
                end
            end
            pdbl_pkg::ST_DER: begin
                mul_a         = {4'h0, lim_diff};
                mul_b         = {13'h0000, temp_off};
                div_req.start = 1'b1;
                state_next    = pdbl_pkg::ST_DER_WAIT;
            end
            pdbl_pkg::ST_DER_WAIT: begin
                if (div_rsp.done) begin
                    target_next = (der_limit < target_normal_reg) ?
                                  der_limit : target_normal_reg;
                    state_next  = pdbl_pkg::ST_STEP;
                end
            end
            pdbl_pkg::ST_STEP: begin
                if (err < -pdbl_pkg::ERR_BAND) begin
                    bias_s  = bias_s + pdbl_pkg::STEP_COARSE;
                    err_big = 1'b1;
                end else if (err < 0) begin
                    bias_s = bias_s + pdbl_pkg::STEP_FINE;
                end else if (err == 0) begin
                    bias_s = bias_s;
                end else if (err < pdbl_pkg::ERR_BAND) begin
                    bias_s = bias_s - pdbl_pkg::STEP_FINE;
                end else begin
                    bias_s  = bias_s - pdbl_pkg::STEP_COARSE;
                    err_big = 1'b1;
                end
                if (bias_s < 0) begin
                    bias_next = '0;
                end else if (bias_s > $signed({2'b00, vref_max_reg})) begin
                    bias_next = vref_max_reg;
                end else begin
                    bias_next = bias_s[pdbl_pkg::MV_W-1:0];
                end
                cd_load        = err_big ? pdbl_pkg::SAVE_HOLD : cd_reg;
                save_next      = 1'b0;
                save_bias_next = '0;
                cd_next        = cd_load;
                if (cd_load != '0) begin
                    cd_next = cd_load - 1'b1;
                    if (cd_load == 7'd1 && temp_reg < temp_warning_reg) begin
                        save_next      = 1'b1;
                        save_bias_next = bias_next;
                    end
                end
                state_next = pdbl_pkg::ST_DAC;
            end
            pdbl_pkg::ST_DAC: begin
                // bias * 273/220 in 20-bit fixed point
                mul_a      = {4'h0, bias_reg};
                mul_b      = pdbl_pkg::DAC_RECIP;
                prod_next  = product;
                state_next = pdbl_pkg::ST_DAC_FIX;
            end
            pdbl_pkg::ST_DAC_FIX: begin
                // bias above 3300 saturates the code
                dac_next   = prod_reg[pdbl_pkg::DAC_SHIFT+pdbl_pkg::MV_W] ? pdbl_pkg::DAC_MAX :
                             prod_reg[pdbl_pkg::DAC_SHIFT+pdbl_pkg::MV_W-1:pdbl_pkg::DAC_SHIFT];
                state_next = pdbl_pkg::ST_DONE;
            end
            pdbl_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'b000, save_bias_reg, save_reg, target_reg,
                                    meas_reg, bias_reg, dac_reg};
                    state_next   = pdbl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdbl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pdbl_pkg::ST_IDLE;
            bias_reg    <= '0;
            cd_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bias_reg    <= bias_next;
            cd_reg      <= cd_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg    <= sample_next;
        temp_reg      <= temp_next;
        meas_reg      <= meas_next;
        target_reg    <= target_next;
        save_reg      <= save_next;
        save_bias_reg <= save_bias_next;
        dac_reg       <= dac_next;
        prod_reg      <= prod_next;
        m_data_reg    <= m_data_next;
    end

    `PDBL_ASSERT_ALWAYS(a_save_bias_match,
        !(m_valid_reg && m_data_reg[48]) || (m_data_reg[60:49] == m_data_reg[23:12]),
        "save bias differs from bias")
    `PDBL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
        "second word taken while busy")
    `PDBL_ASSERT_ALWAYS(a_cd_bound, cd_reg < pdbl_pkg::SAVE_HOLD,
        "save countdown out of range")

endmodule

`default_nettype wire
